### sv/frs_pkg.sv
`timescale 1ns / 1ps

package frs_pkg;

    // Payload widths of the channels
    localparam int CMD_W = 2;
    localparam int REC_W = 3;
    localparam int VAL_W = 32;
    localparam int IDX_W = 11;
    localparam int CFG_W = 6;

    // Default geometry
    localparam int DEF_NUM_RECORDS  = 6;
    localparam int DEF_SECTOR_WORDS = 1024;

    // Flash word patterns
    localparam logic [VAL_W-1:0] TAG_WORD    = 32'hABAB_ABAB;
    localparam logic [VAL_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

    // Command codes
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_SAVE = 2'd0;
    localparam t_cmd CMD_LOAD = 2'd1;
    localparam t_cmd CMD_SCAN = 2'd2;

endpackage

### sv/frs_channels.sv
`timescale 1ns / 1ps

// Request channel: one command against one record
interface frs_req_if;
    logic                       valid;
    logic                       ready;
    logic [frs_pkg::CMD_W-1:0]  command;
    logic [frs_pkg::REC_W-1:0]  record;
    logic [frs_pkg::VAL_W-1:0]  value_in;

    modport source (output valid, output command, output record, output value_in,
                    input ready);
    modport sink   (input valid, input command, input record, input value_in,
                    output ready);
endinterface

// Response channel: one result per request
interface frs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [frs_pkg::VAL_W-1:0]  value_out;
    logic [frs_pkg::IDX_W-1:0]  slot_index;
    logic                       sector_erased;

    modport source (output valid, output value_out, output slot_index,
                    output sector_erased, input ready);
    modport sink   (input valid, input value_out, input slot_index,
                    input sector_erased, output ready);
endinterface

// Configuration write channel: tagged_records register
interface frs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [frs_pkg::CFG_W-1:0]  tagged_records;

    modport source (output valid, output tagged_records, input ready);
    modport sink   (input valid, input tagged_records, output ready);
endinterface

### sv/frs_ram.sv
`timescale 1ns / 1ps

module frs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/flash_record_ring_store.sv
// Request to result: decode, then a load reads one slot word; a save reads and programs its slot,
// the header word first when tagged, after erasing the sector if needed; a scan reads slot by slot.
// Throughput: one request at a time; the next request is taken the cycle after the
// result enters the output register, each step being one access of the slot memory port.
// Reset (i_rst_n low, synchronous): pointers zero, tagged_records = 1, then a clearing
// pass writes all ones to NUM_RECORDS*SECTOR_WORDS words, one per cycle, requests held off.
`timescale 1ns / 1ps

module flash_record_ring_store #(
    parameter int NUM_RECORDS  = frs_pkg::DEF_NUM_RECORDS,
    parameter int SECTOR_WORDS = frs_pkg::DEF_SECTOR_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frs_req_if.sink    i_req,
    frs_rsp_if.source  o_rsp,
    frs_cfg_if.sink    i_cfg
);

    // Geometry
    localparam int DEPTH      = NUM_RECORDS * SECTOR_WORDS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W      = $clog2(SECTOR_WORDS + 1);
    localparam int REC_IDX_W  = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
    localparam logic [PTR_W-1:0] SLOTS_PLAIN = PTR_W'(SECTOR_WORDS);
    localparam logic [PTR_W-1:0] SLOTS_TAG   = PTR_W'(SECTOR_WORDS / 2);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // reset clearing pass over the whole store
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request
    localparam logic [2:0] S_DEC   = 3'd2;  // decode command, pick slot
    localparam logic [2:0] S_ERASE = 3'd3;  // sweep the record's sector to all ones
    localparam logic [2:0] S_RD    = 3'd4;  // issue read of one slot word
    localparam logic [2:0] S_WAIT  = 3'd5;  // read data back: capture or program
    localparam logic [2:0] S_SCAN  = 3'd6;  // pipelined search for first erased slot
    localparam logic [2:0] S_DONE  = 3'd7;  // hand result to the output register

    // Word offset of a slot inside its sector; hdr selects the header word of a
    // tagged slot, plain slots have a single word
    function automatic logic [AW-1:0] word_ofs(input logic [PTR_W-1:0] slot,
                                                input logic tag, input logic hdr);
        logic [AW-1:0] s;
        s = AW'(slot);
        word_ofs = tag ? ((s << 1) | AW'(!hdr)) : s;
    endfunction

    // Registers
    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_cnt, n_cnt;
    logic [frs_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [frs_pkg::REC_W-1:0] r_rec, n_rec;
    logic [frs_pkg::VAL_W-1:0] r_val, n_val;
    logic [AW-1:0]             r_base, n_base;
    logic [AW-1:0]             r_addr, n_addr;
    logic [PTR_W-1:0]          r_idx, n_idx;
    logic                      r_hdr, n_hdr;
    logic [frs_pkg::VAL_W-1:0] r_vout, n_vout;
    logic                      r_erased, n_erased;
    logic [PTR_W-1:0]          r_scan_i, n_scan_i;
    logic                      r_chk_v, n_chk_v;
    logic [PTR_W-1:0]          r_chk_i, n_chk_i;
    logic [PTR_W-1:0]          r_next [NUM_RECORDS];
    logic [PTR_W-1:0]          n_next [NUM_RECORDS];
    logic [frs_pkg::CFG_W-1:0] r_tagged, n_tagged;

    // Output register
    logic                      r_ov, n_ov;
    logic [frs_pkg::VAL_W-1:0] r_o_vout, n_o_vout;
    logic [frs_pkg::IDX_W-1:0] r_o_idx, n_o_idx;
    logic                      r_o_erased, n_o_erased;

    // Memory port
    logic                      c_we;
    logic [AW-1:0]             c_waddr;
    logic [frs_pkg::VAL_W-1:0] c_wdata;
    logic [AW-1:0]             c_raddr;
    logic [frs_pkg::VAL_W-1:0] c_rdata;

    // Decode helpers
    logic [REC_IDX_W-1:0]      c_rec_i;
    logic                      c_rec_ok;
    logic                      c_tag;
    logic [PTR_W-1:0]          c_n;
    logic [PTR_W-1:0]          c_ptr;
    logic [PTR_W-1:0]          c_p;
    logic                      c_hit;
    logic                      c_req_acc;
    logic                      c_out_free;

    assign c_rec_i    = r_rec[REC_IDX_W-1:0];
    assign c_rec_ok   = r_rec < frs_pkg::REC_W'(NUM_RECORDS);
    assign c_tag      = c_rec_ok && r_tagged[c_rec_i];
    assign c_n        = c_tag ? SLOTS_TAG : SLOTS_PLAIN;
    assign c_ptr      = r_next[c_rec_i];
    assign c_p        = (c_ptr > c_n) ? c_n : c_ptr;   // clamp a pointer left over from a mode change
    assign c_hit      = c_tag ? (c_rdata != frs_pkg::TAG_WORD)
                              : (c_rdata == frs_pkg::ERASED_WORD);
    assign c_req_acc  = i_req.valid && i_req.ready;
    assign c_out_free = !r_ov || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_rec      = r_rec;
        n_val      = r_val;
        n_base     = r_base;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_hdr      = r_hdr;
        n_vout     = r_vout;
        n_erased   = r_erased;
        n_scan_i   = r_scan_i;
        n_chk_v    = r_chk_v;
        n_chk_i    = r_chk_i;
        n_next     = r_next;
        n_tagged   = (i_cfg.valid && i_cfg.ready) ? i_cfg.tagged_records : r_tagged;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_vout   = r_o_vout;
        n_o_idx    = r_o_idx;
        n_o_erased = r_o_erased;
        c_we       = 1'b0;
        c_waddr    = r_addr;
        c_wdata    = frs_pkg::ERASED_WORD;
        c_raddr    = r_base + word_ofs(r_idx, c_tag, r_hdr);

        unique case (r_state)
            S_CLEAR: begin
                // Write all ones across the store after reset
                c_we    = 1'b1;
                c_waddr = r_cnt;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (c_req_acc) begin
                    n_cmd   = i_req.command;
                    n_rec   = i_req.record;
                    n_val   = i_req.value_in;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_base   = AW'(c_rec_i) * AW'(SECTOR_WORDS);
                n_vout   = '0;
                n_erased = 1'b0;
                n_idx    = '0;
                n_hdr    = 1'b0;
                n_state  = S_DONE;
                if (c_rec_ok) begin
                    unique case (r_cmd)
                        frs_pkg::CMD_SAVE: begin
                            // Erase first when the next slot would be the last one
                            if (({1'b0, c_ptr} + 1'b1) >= {1'b0, c_n}) begin
                                n_erased = 1'b1;
                                n_cnt    = '0;
                                n_state  = S_ERASE;
                            end else begin
                                n_idx   = c_ptr;
                                n_hdr   = c_tag;
                                n_state = S_RD;
                            end
                        end
                        frs_pkg::CMD_LOAD: begin
                            n_idx   = (c_p == '0) ? '0 : c_p - 1'b1;
                            n_state = S_RD;
                        end
                        frs_pkg::CMD_SCAN: begin
                            n_scan_i = '0;
                            n_chk_v  = 1'b0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            // Unknown command: all-zero result, no effect
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ERASE: begin
                c_we    = 1'b1;
                c_waddr = r_base + r_cnt;
                if (r_cnt == AW'(SECTOR_WORDS - 1)) begin
                    n_next[c_rec_i] = '0;
                    n_idx           = '0;
                    n_hdr           = c_tag;
                    n_state         = S_RD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_RD: begin
                // Hold the address for the write-back of a save
                n_addr  = c_raddr;
                n_state = S_WAIT;
            end

            S_WAIT: begin
                if (r_cmd == frs_pkg::CMD_LOAD) begin
                    n_vout  = c_rdata;
                    n_state = S_DONE;
                end else begin
                    // NOR programming only clears bits: AND old contents with new data
                    c_we    = 1'b1;
                    c_waddr = r_addr;
                    c_wdata = c_rdata & (r_hdr ? frs_pkg::TAG_WORD : r_val);
                    if (r_hdr) begin
                        n_hdr   = 1'b0;
                        n_state = S_RD;
                    end else begin
                        n_next[c_rec_i] = r_idx + 1'b1;
                        n_state         = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // Issue one read per cycle, check the word read in the cycle before
                c_raddr = r_base + word_ofs(r_scan_i, c_tag, 1'b1);
                if (r_chk_v && c_hit) begin
                    n_next[c_rec_i] = r_chk_i;
                    n_idx           = r_chk_i;
                    n_state         = S_DONE;
                end else if (r_scan_i >= c_n) begin
                    n_next[c_rec_i] = c_n;
                    n_idx           = c_n;
                    n_state         = S_DONE;
                end else begin
                    n_chk_v  = 1'b1;
                    n_chk_i  = r_scan_i;
                    n_scan_i = r_scan_i + 1'b1;
                end
            end

            S_DONE: begin
                // Wait for room in the output register
                if (c_out_free) begin
                    n_ov       = 1'b1;
                    n_o_vout   = r_vout;
                    n_o_idx    = frs_pkg::IDX_W'(r_idx);
                    n_o_erased = r_erased;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_tagged <= frs_pkg::CFG_W'(1);
            r_ov     <= 1'b0;
            r_chk_v  <= 1'b0;
            for (int i = 0; i < NUM_RECORDS; i++) begin
                r_next[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_tagged <= n_tagged;
            r_ov     <= n_ov;
            r_chk_v  <= n_chk_v;
            r_next   <= n_next;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_rec      <= n_rec;
        r_val      <= n_val;
        r_base     <= n_base;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_hdr      <= n_hdr;
        r_vout     <= n_vout;
        r_erased   <= n_erased;
        r_scan_i   <= n_scan_i;
        r_chk_i    <= n_chk_i;
        r_o_vout   <= n_o_vout;
        r_o_idx    <= n_o_idx;
        r_o_erased <= n_o_erased;
    end

    // Slot store: one write and one registered read per cycle
    frs_ram #(
        .WIDTH  (frs_pkg::VAL_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_slot_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign o_rsp.valid         = r_ov;
    assign o_rsp.value_out     = r_o_vout;
    assign o_rsp.slot_index    = r_o_idx;
    assign o_rsp.sector_erased = r_o_erased;

endmodule

### sv/frs_chk.sv
`timescale 1ns / 1ps

module frs_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [frs_pkg::VAL_W-1:0] i_rsp_value_out,
    input logic [frs_pkg::IDX_W-1:0] i_rsp_slot_index,
    input logic                      i_rsp_sector_erased
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // One request at a time: no request taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !(i_req_valid && i_req_ready))
        else $error("request taken while one is in progress");

    // Clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request ready before clearing pass");

    // A save that erased writes slot 0 and returns no value
    a_erase_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_sector_erased) |->
            (i_rsp_value_out == '0 && i_rsp_slot_index == '0))
        else $error("erasing save returned nonzero fields");

endmodule

bind flash_record_ring_store frs_chk u_frs_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_value_out     (o_rsp.value_out),
    .i_rsp_slot_index    (o_rsp.slot_index),
    .i_rsp_sector_erased (o_rsp.sector_erased)
);

### tb/flash_record_checker.sv
`timescale 1ns / 1ps

module flash_record_checker #(
    parameter int NUM_RECORDS  = frs_pkg::DEF_NUM_RECORDS,
    parameter int SECTOR_WORDS = frs_pkg::DEF_SECTOR_WORDS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frs_req_if   i_req,
    frs_rsp_if   i_rsp,
    frs_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_erase_count
);
    import frs_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [IDX_W-1:0] slot_index;
        logic             sector_erased;
    } t_outcome;

    logic [VAL_W-1:0] flash_words [NUM_RECORDS*SECTOR_WORDS];
    logic [IDX_W-1:0] next_slot   [NUM_RECORDS];
    logic [CFG_W-1:0] tagged_mask;
    t_outcome         awaited_results [$];
    int               fails;
    int               erases;

    // Word address of the value word of one slot
    function automatic int value_addr(int rec, int slot);
        return tagged_mask[rec] ? rec * SECTOR_WORDS + 2 * slot + 1
                                : rec * SECTOR_WORDS + slot;
    endfunction

    function automatic t_outcome apply_request(t_cmd cmd, logic [REC_W-1:0] rec_bits,
                                               logic [VAL_W-1:0] val);
        t_outcome res;
        int       rec;
        int       slots;
        int       base;
        int       ptr;
        int       addr;
        int       i;
        res = '0;
        rec = int'(rec_bits);
        if (rec >= NUM_RECORDS) begin
            return res;
        end
        slots = tagged_mask[rec] ? SECTOR_WORDS / 2 : SECTOR_WORDS;
        base  = rec * SECTOR_WORDS;
        case (cmd)
            CMD_SAVE: begin
                if (int'(next_slot[rec]) + 1 >= slots) begin
                    for (i = 0; i < SECTOR_WORDS; i++) begin
                        flash_words[base + i] = ERASED_WORD;
                    end
                    next_slot[rec]    = '0;
                    res.sector_erased = 1'b1;
                end
                res.slot_index = next_slot[rec];
                addr = value_addr(rec, int'(next_slot[rec]));
                if (tagged_mask[rec]) begin
                    flash_words[addr - 1] &= TAG_WORD;
                end
                flash_words[addr] &= val;
                next_slot[rec] = next_slot[rec] + 1'b1;
            end
            CMD_LOAD: begin
                ptr = int'(next_slot[rec]);
                if (ptr > slots) begin
                    ptr = slots;
                end
                ptr = (ptr == 0) ? 0 : ptr - 1;
                res.slot_index = IDX_W'(ptr);
                res.value_out  = flash_words[value_addr(rec, ptr)];
            end
            CMD_SCAN: begin
                ptr = 0;
                while (ptr < slots &&
                       (tagged_mask[rec] ? flash_words[base + 2 * ptr] == TAG_WORD
                                         : flash_words[base + ptr] != ERASED_WORD)) begin
                    ptr++;
                end
                next_slot[rec] = IDX_W'(ptr);
                res.slot_index = IDX_W'(ptr);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        int       i;
        if (!i_rst_n) begin
            for (i = 0; i < NUM_RECORDS * SECTOR_WORDS; i++) begin
                flash_words[i] = ERASED_WORD;
            end
            for (i = 0; i < NUM_RECORDS; i++) begin
                next_slot[i] = '0;
            end
            tagged_mask = CFG_W'(1);
            awaited_results.delete();
            fails  = 0;
            erases = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                tagged_mask = i_cfg.tagged_records;
            end
            if (i_req.valid && i_req.ready) begin
                awaited_results.push_back(apply_request(i_req.command, i_req.record,
                                                        i_req.value_in));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("response with no request outstanding");
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.sector_erased) begin
                        erases++;
                    end
                    if (i_rsp.value_out !== want.value_out) begin
                        $error("value_out: expected %h, actual %h",
                               want.value_out, i_rsp.value_out);
                        fails++;
                    end
                    if (i_rsp.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, i_rsp.slot_index);
                        fails++;
                    end
                    if (i_rsp.sector_erased !== want.sector_erased) begin
                        $error("sector_erased: expected %0b, actual %0b",
                               want.sector_erased, i_rsp.sector_erased);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= awaited_results.size();
        o_erase_count <= erases;
    end

endmodule

### tb/flash_record_ring_store_test.sv
`timescale 1ns / 1ps

module flash_record_ring_store_test;
    import frs_pkg::*;

    localparam int   NUM_RECORDS    = DEF_NUM_RECORDS;
    localparam int   SECTOR_WORDS   = DEF_SECTOR_WORDS;
    // Idle cycles allowed: covers the clearing pass after reset, a full sector
    // erase or scan, and the longest gap on either side, several times over.
    localparam int   WATCHDOG_LIMIT = 40000;
    localparam t_cmd CMD_UNUSED     = 2'd3;
    // Record kept free of saves until the long fills below
    localparam int   SPARE_RECORD   = NUM_RECORDS - 1;
    localparam logic [CFG_W-1:0] ALL_PLAIN   = '0;
    localparam logic [CFG_W-1:0] ALL_TAGGED  = '1;
    localparam logic [CFG_W-1:0] SPARE_PLAIN = ALL_TAGGED ^ (CFG_W'(1) << SPARE_RECORD);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    frs_req_if req_ch ();
    frs_rsp_if rsp_ch ();
    frs_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int erase_count;
    int request_count = 0;
    int config_count  = 0;
    bit calm          = 1'b0;   // set for stretches without any idling
    int stall_left    = 0;

    always #2 i_clk = ~i_clk;

    flash_record_ring_store #(
        .NUM_RECORDS  (NUM_RECORDS),
        .SECTOR_WORDS (SECTOR_WORDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    flash_record_checker #(
        .NUM_RECORDS  (NUM_RECORDS),
        .SECTOR_WORDS (SECTOR_WORDS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_erase_count (erase_count)
    );

    // Drive every block input to a known value before the first edge
    initial begin
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_SAVE;
        req_ch.record         = '0;
        req_ch.value_in       = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.tagged_records = '0;
    end

    // Gap length: mostly none or short, now and then a long one
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(3, 1);
        end else if (roll < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(80, 20);
    endfunction

    // Value mix: corner patterns often, random words otherwise
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return ERASED_WORD;
            2: return TAG_WORD;
            default: return $urandom;
        endcase
    endfunction

    // Result sink: stall in random bursts, hold ready low through reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(99) < 30) begin
                stall_left = gap_length();
            end
        end
    end

    // Present one request and hold it until the block takes it.
    // Keep valid high across back-to-back requests; drop it only for a gap.
    task automatic send_request(t_cmd cmd, int rec, logic [VAL_W-1:0] val);
        int gap;
        gap = calm ? 0 : gap_length();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.record   <= REC_W'(rec);
        req_ch.value_in <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        request_count++;
    endtask

    // Drop valid and wait until every outstanding request has its result.
    // Sample the count at the falling edge, clear of the rising-edge updates.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write the tagged-record mask with the block idle
    task automatic write_mask(logic [CFG_W-1:0] mask);
        settle();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.tagged_records <= mask;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        config_count++;
    endtask

    // Append saves to the spare record; skip all-ones values so that every
    // written word reads as programmed to a later plain scan.
    task automatic fill_spare(int count);
        logic [VAL_W-1:0] val;
        repeat (count) begin
            do begin
                val = $urandom;
            end while (val == ERASED_WORD);
            send_request(CMD_SAVE, SPARE_RECORD, val);
        end
    endtask

    // Random mix: one record takes most of the traffic so its pointer climbs,
    // a few requests name a missing record or the unused command.
    task automatic random_phase(int count, int focus);
        int   rec;
        int   roll;
        t_cmd cmd;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                rec = $urandom_range(2 ** REC_W - 1, NUM_RECORDS);
            end else if (roll < 60) begin
                rec = focus;
            end else begin
                rec = $urandom_range(NUM_RECORDS - 1);
            end
            roll = $urandom_range(99);
            if (roll < 5) begin
                cmd = CMD_UNUSED;
            end else if (roll < 55) begin
                cmd = CMD_SAVE;
            end else if (roll < 80) begin
                cmd = CMD_LOAD;
            end else begin
                cmd = CMD_SCAN;
            end
            send_request(cmd, rec, pick_value());
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: register at its reset value, record 0 tagged, rest plain.
        // Load and scan an empty tagged sector, then save the extreme values.
        send_request(CMD_LOAD, 0, '0);
        send_request(CMD_SCAN, 0, ERASED_WORD);
        send_request(CMD_SAVE, 0, '0);
        send_request(CMD_SAVE, 0, ERASED_WORD);
        send_request(CMD_LOAD, 0, '0);
        send_request(CMD_SCAN, 0, '0);
        // Plain record: an all-ones save still reads as erased to a scan
        send_request(CMD_SAVE, 1, ERASED_WORD);
        send_request(CMD_SCAN, 1, '0);
        send_request(CMD_SAVE, 1, TAG_WORD);
        send_request(CMD_SAVE, 1, 32'h1234_5678);
        send_request(CMD_LOAD, 1, '0);
        send_request(CMD_LOAD, 2, '0);
        send_request(CMD_SAVE, 4, 32'h8000_0001);
        send_request(CMD_LOAD, 4, '0);
        send_request(CMD_SCAN, 3, '0);
        // Unknown command and missing records: all-zero results, no effect
        send_request(CMD_UNUSED, 0, 32'hDEAD_BEEF);
        send_request(CMD_SAVE, 6, 32'h0F0F_0F0F);
        send_request(CMD_LOAD, 7, '0);
        send_request(CMD_SCAN, 7, '0);
        send_request(CMD_UNUSED, 7, ERASED_WORD);
        send_request(CMD_SAVE, 0, 32'h5555_AAAA);
        send_request(CMD_LOAD, 0, '0);
        // Mode change: read the tagged words of record 0 with the plain layout
        write_mask(ALL_PLAIN);
        send_request(CMD_LOAD, 0, '0);
        send_request(CMD_SCAN, 0, '0);
        send_request(CMD_LOAD, SPARE_RECORD, '0);
        send_request(CMD_SCAN, SPARE_RECORD, '0);

        // Fill the spare record's tagged sector up to its last usable slot
        write_mask(ALL_TAGGED);
        fill_spare(SECTOR_WORDS / 2 - 1);
        send_request(CMD_LOAD, SPARE_RECORD, '0);
        send_request(CMD_SCAN, SPARE_RECORD, '0);
        // Same words seen as plain: the scan lands just short of the sector end
        write_mask(SPARE_PLAIN);
        send_request(CMD_SCAN, SPARE_RECORD, '0);
        send_request(CMD_LOAD, SPARE_RECORD, '0);
        // Pointer beyond the tagged slot count: the load clamps it
        write_mask(ALL_TAGGED);
        send_request(CMD_LOAD, SPARE_RECORD, '0);
        // Back to plain: one save into the next-to-last slot, then one that erases
        write_mask(SPARE_PLAIN);
        send_request(CMD_SAVE, SPARE_RECORD, pick_value());
        send_request(CMD_SAVE, SPARE_RECORD, pick_value());
        send_request(CMD_LOAD, SPARE_RECORD, '0);
        // Tagged again: run the pointer past the end so the sector erases
        write_mask(ALL_TAGGED);
        send_request(CMD_SCAN, SPARE_RECORD, '0);
        fill_spare(SECTOR_WORDS / 2 + 8);
        send_request(CMD_LOAD, SPARE_RECORD, '0);

        // Random phases over several register settings
        write_mask(ALL_PLAIN);
        random_phase(100, 1);
        write_mask(6'h2A);
        calm = 1'b1;
        random_phase(100, 3);
        calm = 1'b0;
        write_mask(6'h15);
        random_phase(100, 0);
        write_mask(CFG_W'($urandom_range(2 ** CFG_W - 1)));
        random_phase(100, $urandom_range(NUM_RECORDS - 1));

        // Drain, then give the block time to show any stray result
        settle();
        repeat (SECTOR_WORDS + 16) @(posedge i_clk);

        $display("Ran %0d requests under %0d mask settings; %0d saves erased a sector.",
                 request_count, config_count, erase_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: end the run when no channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired after %0d idle cycles.", idle_cycles);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
